### hdl/wpts_pkg.sv
// Shared types, constants and codes of the windowed phase timing statistics block.
`default_nettype none

package wpts_pkg;

   localparam int PHASES     = 32;
   localparam int RESULT_CAP = 32;
   localparam int EMIT_COUNT = (PHASES < RESULT_CAP) ? PHASES : RESULT_CAP;
   localparam int IDX_W      = (EMIT_COUNT > 1) ? $clog2(EMIT_COUNT) : 1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE        = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_FRAMES = 1'b1;

   localparam logic [15:0] WINDOW_FRAMES_RESET = 16'd600;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [63:0] total;
      logic [63:0] peak;
      logic [31:0] calls;
   } stat_type;

   typedef struct packed {
      logic        clear;
      logic        shift;
      logic        wr_en;
      logic [63:0] duration;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### hdl/wpts_req_if.sv
// Input item channel: valid/ready handshake with sample and frame tick fields.
`default_nettype none

interface wpts_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [4:0]         phase_id;
   logic [63:0]        start_time;
   logic [63:0]        end_time;
   logic signed [31:0] stage_number;
   logic [31:0]        stage_frame;
   logic [7:0]         cadence;
   logic               replay_flag;
   logic [7:0]         demo_mode;

   modport source (
      output valid, operation, phase_id, start_time, end_time, stage_number,
             stage_frame, cadence, replay_flag, demo_mode,
      input  ready
   );

   modport sink (
      input  valid, operation, phase_id, start_time, end_time, stage_number,
             stage_frame, cadence, replay_flag, demo_mode,
      output ready
   );
endinterface

`default_nettype wire

### hdl/wpts_rsp_if.sv
// Result item channel: valid/ready handshake with per-phase statistics fields.
`default_nettype none

interface wpts_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  phase_index;
   logic [63:0] total_time;
   logic [63:0] max_time;
   logic [31:0] call_count;
   logic [31:0] draw_count;
   logic [63:0] wall_time;
   logic [31:0] first_frame;
   logic [31:0] final_frame;
   logic [31:0] regressions;
   logic        last;

   modport source (
      output valid, phase_index, total_time, max_time, call_count, draw_count,
             wall_time, first_frame, final_frame, regressions, last,
      input  ready
   );

   modport sink (
      input  valid, phase_index, total_time, max_time, call_count, draw_count,
             wall_time, first_frame, final_frame, regressions, last,
      output ready
   );
endinterface

`default_nettype wire

### hdl/wpts_cell.sv
// One phase statistics cell: saturating total, peak and call count, shifts to its neighbor.
`default_nettype none

module wpts_cell (
   input  wire                      clock,
   input  wire                      reset,
   input  wpts_pkg::cell_ctrl_type  ctrl,
   input  wire                      hit,
   input  wpts_pkg::stat_type       next_stat,
   output wpts_pkg::stat_type       stat
);
   import wpts_pkg::*;

   stat_type    stat_ff;
   stat_type    stat_in;
   logic [64:0] sum;

   always_comb begin
      sum     = {1'b0, stat_ff.total} + {1'b0, ctrl.duration};
      stat_in = stat_ff;
      if (ctrl.clear) begin
         stat_in = '0;
      end else if (ctrl.shift) begin
         stat_in = next_stat;
      end else if (ctrl.wr_en && hit) begin
         // saturate the total, keep the peak, saturate the count
         stat_in.total = sum[64] ? {64{1'b1}} : sum[63:0];
         if (ctrl.duration > stat_ff.peak) begin
            stat_in.peak = ctrl.duration;
         end
         if (stat_ff.calls != {32{1'b1}}) begin
            stat_in.calls = stat_ff.calls + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff <= '0;
      end else begin
         stat_ff <= stat_in;
      end
   end

   assign stat = stat_ff;

endmodule

`default_nettype wire

### hdl/windowed_phase_timing_stats.sv
// Top level: window control, sample stage, row of phase cells and result register.
// Samples and non-emitting ticks are accepted back to back unless a result waits.
// A sample is registered in the difference stage and lands in its cell the cycle after.
// A tick that reaches the target frame shifts the cell row out into the result register,
// one phase per cycle while it is free; the input is held until the last result leaves.
// Synchronous reset clears the cells, window state and control registers at once.
`default_nettype none

module windowed_phase_timing_stats (
   input  wire                                clock,
   input  wire                                reset,
   wpts_req_if.sink                           req_if,
   wpts_rsp_if.source                         rsp_if,
   input  wire                                csr_we,
   input  wire [wpts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [wpts_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import wpts_pkg::*;

   // configuration
   logic        enable_ff, enable_in;
   logic [15:0] window_frames_ff, window_frames_in;

   // window state
   logic               window_open_ff, window_open_in;
   logic signed [31:0] window_stage_ff, window_stage_in;
   logic [31:0]        previous_frame_ff, previous_frame_in;
   logic [31:0]        baseline_frame_ff, baseline_frame_in;
   logic [31:0]        target_frame_ff, target_frame_in;
   logic [31:0]        draws_ff, draws_in;
   logic [7:0]         window_cadence_ff, window_cadence_in;
   logic               window_replay_ff, window_replay_in;
   logic [7:0]         window_demo_ff, window_demo_in;
   logic [63:0]        window_start_ff, window_start_in;
   logic [31:0]        regression_count_ff, regression_count_in;

   // pending sample, one stage ahead of the cells
   logic        smp_valid_ff, smp_valid_in;
   logic [4:0]  smp_phase_ff, smp_phase_in;
   logic [63:0] smp_dur_ff, smp_dur_in;

   // values shared by every result of one window
   logic [31:0] snap_draws_ff, snap_draws_in;
   logic [63:0] snap_wall_ff, snap_wall_in;
   logic [31:0] snap_first_ff, snap_first_in;
   logic [31:0] snap_final_ff, snap_final_in;
   logic [31:0] snap_regr_ff, snap_regr_in;

   // emission control
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   emit_cnt_ff, emit_cnt_in;
   logic               emit_go;
   logic               emit_step;
   logic               emit_last;
   logic               in_ready;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  rsp_phase_ff;
   stat_type    rsp_stat_ff;
   logic        rsp_last_ff;

   // cell row
   cell_ctrl_type cell_ctrl;
   logic          begin_clear;
   stat_type      cell_stat [EMIT_COUNT];

   logic        accept;
   logic        tick_go;
   logic        restart;
   logic [32:0] target_sum;
   logic [31:0] target_new;
   logic [31:0] draws_next;
   logic [31:0] regr_next;
   logic        back_step;

   assign accept = req_if.valid && in_ready;

   // ---------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------
   always_comb begin
      enable_in        = enable_ff;
      window_frames_in = window_frames_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:        enable_in        = csr_wdata[0];
            CSR_WINDOW_FRAMES: window_frames_in = csr_wdata[15:0];
            default:           enable_in        = enable_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // window control: samples touch only the regression count and the
   // pending-sample stage; ticks open, close, restart or end the window
   // ---------------------------------------------------------------
   always_comb begin
      window_open_in      = window_open_ff;
      window_stage_in     = window_stage_ff;
      previous_frame_in   = previous_frame_ff;
      baseline_frame_in   = baseline_frame_ff;
      target_frame_in     = target_frame_ff;
      draws_in            = draws_ff;
      window_cadence_in   = window_cadence_ff;
      window_replay_in    = window_replay_ff;
      window_demo_in      = window_demo_ff;
      window_start_in     = window_start_ff;
      regression_count_in = regression_count_ff;

      smp_valid_in = 1'b0;
      smp_phase_in = req_if.phase_id;
      smp_dur_in   = req_if.end_time - req_if.start_time;

      snap_draws_in = snap_draws_ff;
      snap_wall_in  = snap_wall_ff;
      snap_first_in = snap_first_ff;
      snap_final_in = snap_final_ff;
      snap_regr_in  = snap_regr_ff;

      begin_clear = 1'b0;
      emit_go     = 1'b0;
      restart     = 1'b0;

      // target of a window that would start at this tick's frame
      target_sum = {1'b0, req_if.stage_frame} + {17'd0, window_frames_ff};
      target_new = target_sum[32] ? 32'd0 : target_sum[31:0];
      draws_next = draws_ff + 32'd1;
      back_step  = req_if.end_time < window_start_ff;
      regr_next  = regression_count_ff;
      if (back_step && regression_count_ff != {32{1'b1}}) begin
         regr_next = regression_count_ff + 32'd1;
      end

      tick_go = accept && req_if.operation == OP_TICK && enable_ff;

      if (accept && req_if.operation == OP_SAMPLE && window_open_ff) begin
         if (req_if.end_time < req_if.start_time) begin
            if (regression_count_ff != {32{1'b1}}) begin
               regression_count_in = regression_count_ff + 32'd1;
            end
         end else if ({1'b0, req_if.phase_id} < 6'(EMIT_COUNT)) begin
            smp_valid_in = 1'b1;
         end
      end

      if (tick_go) begin
         if (req_if.stage_frame == 32'd0) begin
            // leave the stage: close and keep the store
            window_open_in = 1'b0;
         end else if (!window_open_ff || req_if.stage_number != window_stage_ff ||
                      req_if.stage_frame <= previous_frame_ff ||
                      req_if.cadence != window_cadence_ff ||
                      req_if.replay_flag != window_replay_ff ||
                      req_if.demo_mode != window_demo_ff) begin
            restart     = 1'b1;
            begin_clear = 1'b1;
         end else if (req_if.stage_frame > target_frame_ff) begin
            restart     = 1'b1;
            begin_clear = 1'b1;
         end else if (req_if.stage_frame == target_frame_ff) begin
            // window complete: latch the shared fields, the cell row is
            // cleared by shifting zeros in while it drains
            restart       = 1'b1;
            emit_go       = 1'b1;
            snap_draws_in = draws_next;
            snap_wall_in  = back_step ? 64'd0 : req_if.end_time - window_start_ff;
            snap_first_in = baseline_frame_ff;
            snap_final_in = req_if.stage_frame;
            snap_regr_in  = regr_next;
         end else begin
            draws_in          = draws_next;
            previous_frame_in = req_if.stage_frame;
         end
      end

      if (restart) begin
         regression_count_in = 32'd0;
         window_stage_in     = req_if.stage_number;
         previous_frame_in   = req_if.stage_frame;
         baseline_frame_in   = req_if.stage_frame;
         target_frame_in     = target_new;
         draws_in            = 32'd0;
         window_cadence_in   = req_if.cadence;
         window_replay_in    = req_if.replay_flag;
         window_demo_in      = req_if.demo_mode;
         window_start_in     = req_if.end_time;
         window_open_in      = target_new != 32'd0;
      end
   end

   // ---------------------------------------------------------------
   // emission sequencer
   // ---------------------------------------------------------------
   assign emit_last = emit_cnt_ff == IDX_W'(EMIT_COUNT - 1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (emit_go) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_step && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold the input while the last result of a window waits: its shared
   // fields come from the snapshot that the next emitting tick reloads
   always_comb begin
      in_ready  = 1'b0;
      emit_step = 1'b0;
      case (state_ff)
         ST_IDLE: in_ready  = !rsp_valid_ff || rsp_if.ready;
         ST_EMIT: emit_step = !rsp_valid_ff || rsp_if.ready;
         default: in_ready  = 1'b0;
      endcase
   end

   always_comb begin
      emit_cnt_in = emit_cnt_ff;
      if (emit_step) begin
         emit_cnt_in = emit_last ? '0 : emit_cnt_ff + IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // cell row: phase i lives in cell i, the row drains toward cell 0
   // ---------------------------------------------------------------
   always_comb begin
      cell_ctrl.clear    = begin_clear;
      cell_ctrl.shift    = emit_step;
      cell_ctrl.wr_en    = smp_valid_ff;
      cell_ctrl.duration = smp_dur_ff;
   end

   for (genvar i = 0; i < EMIT_COUNT; i++) begin : g_cell
      stat_type nbr;
      if (i == EMIT_COUNT - 1) begin : g_end
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = cell_stat[i+1];
      end
      wpts_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .hit       (smp_phase_ff == 5'(i)),
         .next_stat (nbr),
         .stat      (cell_stat[i])
      );
   end

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff           <= 1'b0;
         window_frames_ff    <= WINDOW_FRAMES_RESET;
         window_open_ff      <= 1'b0;
         window_stage_ff     <= -32'sd1;
         previous_frame_ff   <= 32'd0;
         baseline_frame_ff   <= 32'd0;
         target_frame_ff     <= 32'd0;
         draws_ff            <= 32'd0;
         window_cadence_ff   <= 8'd0;
         window_replay_ff    <= 1'b0;
         window_demo_ff      <= 8'd0;
         window_start_ff     <= 64'd0;
         regression_count_ff <= 32'd0;
         smp_valid_ff        <= 1'b0;
         state_ff            <= ST_IDLE;
         emit_cnt_ff         <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         enable_ff           <= enable_in;
         window_frames_ff    <= window_frames_in;
         window_open_ff      <= window_open_in;
         window_stage_ff     <= window_stage_in;
         previous_frame_ff   <= previous_frame_in;
         baseline_frame_ff   <= baseline_frame_in;
         target_frame_ff     <= target_frame_in;
         draws_ff            <= draws_in;
         window_cadence_ff   <= window_cadence_in;
         window_replay_ff    <= window_replay_in;
         window_demo_ff      <= window_demo_in;
         window_start_ff     <= window_start_in;
         regression_count_ff <= regression_count_in;
         smp_valid_ff        <= smp_valid_in;
         state_ff            <= state_in;
         emit_cnt_ff         <= emit_cnt_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      smp_phase_ff  <= smp_phase_in;
      smp_dur_ff    <= smp_dur_in;
      snap_draws_ff <= snap_draws_in;
      snap_wall_ff  <= snap_wall_in;
      snap_first_ff <= snap_first_in;
      snap_final_ff <= snap_final_in;
      snap_regr_ff  <= snap_regr_in;
      if (emit_step) begin
         rsp_phase_ff <= 5'(emit_cnt_ff);
         rsp_stat_ff  <= cell_stat[0];
         rsp_last_ff  <= emit_last;
      end
   end

   // ---------------------------------------------------------------
   // ports
   // ---------------------------------------------------------------
   assign req_if.ready       = in_ready;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.phase_index = rsp_phase_ff;
   assign rsp_if.total_time  = rsp_stat_ff.total;
   assign rsp_if.max_time    = rsp_stat_ff.peak;
   assign rsp_if.call_count  = rsp_stat_ff.calls;
   assign rsp_if.draw_count  = snap_draws_ff;
   assign rsp_if.wall_time   = snap_wall_ff;
   assign rsp_if.first_frame = snap_first_ff;
   assign rsp_if.final_frame = snap_final_ff;
   assign rsp_if.regressions = snap_regr_ff;
   assign rsp_if.last        = rsp_last_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_emit_starts: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> state_ff == ST_EMIT)
      else $error("completed window did not start emission");

   a_last_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> rsp_phase_ff == 5'(EMIT_COUNT - 1))
      else $error("last flag on wrong phase");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> emit_cnt_ff == '0)
      else $error("emission counter not parked while idle");

   a_no_sample_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && $past(state_ff) == ST_EMIT) |-> !smp_valid_ff)
      else $error("sample pending while the cell row drains");

   a_open_target: assert property (@(posedge clock) disable iff (reset)
      window_open_ff |-> target_frame_ff != 32'd0)
      else $error("open window without target frame");

endmodule

`default_nettype wire

### tb/windowed_phase_timing_stats_tb.sv
// Self-checking testbench: per-phase timing statistics, windows, emission and back-pressure.
`timescale 1ns / 1ps

module windowed_phase_timing_stats_tb;
   import wpts_pkg::*;

   // Cycles with no handshake on either channel before the run is declared hung.
   localparam int QUIET_LIMIT  = 4000;
   // Length of the receiver hold-off that fills the block and stalls its input.
   localparam int STALL_CYCLES = 300;
   localparam int ITEM_GOAL    = 300;

   typedef struct {
      logic               operation;
      logic [4:0]         phase_id;
      logic [63:0]        start_time;
      logic [63:0]        end_time;
      logic signed [31:0] stage_number;
      logic [31:0]        stage_frame;
      logic [7:0]         cadence;
      logic               replay_flag;
      logic [7:0]         demo_mode;
   } req_item_type;

   typedef struct {
      logic [4:0]  phase_index;
      logic [63:0] total_time;
      logic [63:0] max_time;
      logic [31:0] call_count;
      logic [31:0] draw_count;
      logic [63:0] wall_time;
      logic [31:0] first_frame;
      logic [31:0] final_frame;
      logic [31:0] regressions;
      logic        last;
   } phase_report_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wpts_req_if req_bus ();
   wpts_rsp_if rsp_bus ();

   windowed_phase_timing_stats dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor state: per-phase store, window bookkeeping and register copies.
   // ---------------------------------------------------------------------------
   logic [63:0] phase_total [PHASES] = '{default: '0};
   logic [63:0] phase_peak  [PHASES] = '{default: '0};
   logic [31:0] phase_calls [PHASES] = '{default: '0};
   logic        win_open     = 1'b0;
   logic [31:0] win_stage    = '1;
   logic [31:0] prev_frame   = '0;
   logic [31:0] base_frame   = '0;
   logic [31:0] target_frame = '0;
   logic [31:0] draw_total   = '0;
   logic [7:0]  win_cadence  = '0;
   logic        win_replay   = 1'b0;
   logic [7:0]  win_demo     = '0;
   logic [63:0] win_start    = '0;
   logic [31:0] clock_regressions = '0;
   logic        cfg_enable   = 1'b0;
   logic [15:0] cfg_frames   = WINDOW_FRAMES_RESET;

   req_item_type     pending_items [$];
   phase_report_type due_reports   [$];
   int               counted_items = 0;
   int               mismatches    = 0;

   // Idling knobs, set between phases by the stimulus process.
   int send_idle_pct = 20;
   int recv_idle_pct = 20;
   int stall_token   = 0;

   // Clear the store and latch the tick as the new window baseline.
   function automatic void restart_window(req_item_type it);
      for (int k = 0; k < PHASES; k++) begin
         phase_total[k] = '0;
         phase_peak[k]  = '0;
         phase_calls[k] = '0;
      end
      clock_regressions = '0;
      win_stage    = it.stage_number;
      prev_frame   = it.stage_frame;
      base_frame   = it.stage_frame;
      // A target past the 32-bit frame range leaves the window closed.
      target_frame = (it.stage_frame <= 32'hFFFF_FFFF - 32'(cfg_frames)) ?
                     it.stage_frame + 32'(cfg_frames) : '0;
      draw_total   = '0;
      win_cadence  = it.cadence;
      win_replay   = it.replay_flag;
      win_demo     = it.demo_mode;
      win_start    = it.end_time;
      win_open     = (target_frame != '0);
   endfunction

   // Apply one accepted item to the predictor and queue the reports it causes.
   function automatic void update_phase_stats(req_item_type it);
      logic [63:0]      dur;
      logic [63:0]      room;
      logic [63:0]      wall;
      phase_report_type rep;
      int               p;
      p = int'(it.phase_id);
      if (it.operation == OP_SAMPLE) begin
         if (!win_open)
            return;
         if (it.end_time < it.start_time) begin
            if (clock_regressions != '1)
               clock_regressions++;
            return;
         end
         if (p >= PHASES)
            return;
         dur  = it.end_time - it.start_time;
         room = 64'hFFFF_FFFF_FFFF_FFFF - phase_total[p];
         phase_total[p] += (dur <= room) ? dur : room;
         if (dur > phase_peak[p])
            phase_peak[p] = dur;
         if (phase_calls[p] != '1)
            phase_calls[p]++;
         return;
      end
      if (!cfg_enable)
         return;
      if (it.stage_frame == '0) begin
         win_open = 1'b0;
         return;
      end
      if (!win_open || it.stage_number != win_stage || it.stage_frame <= prev_frame ||
          it.cadence != win_cadence || it.replay_flag != win_replay ||
          it.demo_mode != win_demo) begin
         restart_window(it);
         return;
      end
      draw_total++;
      prev_frame = it.stage_frame;
      if (it.stage_frame < target_frame)
         return;
      if (it.stage_frame > target_frame) begin
         restart_window(it);
         return;
      end
      // Target reached: one report per phase, then a fresh window at this tick.
      wall = (it.end_time >= win_start) ? it.end_time - win_start : '0;
      if (it.end_time < win_start && clock_regressions != '1)
         clock_regressions++;
      for (int k = 0; k < EMIT_COUNT; k++) begin
         rep.phase_index = k[4:0];
         rep.total_time  = phase_total[k];
         rep.max_time    = phase_peak[k];
         rep.call_count  = phase_calls[k];
         rep.draw_count  = draw_total;
         rep.wall_time   = wall;
         rep.first_frame = base_frame;
         rep.final_frame = it.stage_frame;
         rep.regressions = clock_regressions;
         rep.last        = (k == EMIT_COUNT - 1);
         due_reports.push_back(rep);
      end
      restart_window(it);
   endfunction

   // ---------------------------------------------------------------------------
   // Item builders. Fields an operation ignores still carry random bits.
   // ---------------------------------------------------------------------------
   function automatic req_item_type make_tick(logic [31:0] stage, logic [31:0] frame,
                                              logic [7:0] cad, logic rep, logic [7:0] demo,
                                              logic [63:0] t);
      req_item_type it;
      it.operation    = OP_TICK;
      it.phase_id     = 5'($urandom);
      it.start_time   = {$urandom, $urandom};
      it.end_time     = t;
      it.stage_number = stage;
      it.stage_frame  = frame;
      it.cadence      = cad;
      it.replay_flag  = rep;
      it.demo_mode    = demo;
      return it;
   endfunction

   function automatic req_item_type make_sample(logic [4:0] phase, logic [63:0] t0,
                                                logic [63:0] t1);
      req_item_type it;
      it.operation    = OP_SAMPLE;
      it.phase_id     = phase;
      it.start_time   = t0;
      it.end_time     = t1;
      it.stage_number = $urandom;
      it.stage_frame  = $urandom;
      it.cadence      = 8'($urandom);
      it.replay_flag  = 1'($urandom);
      it.demo_mode    = 8'($urandom);
      return it;
   endfunction

   // Mostly short forward durations; some backwards, some huge, some fully random.
   function automatic req_item_type random_sample(logic [63:0] tnow);
      logic [63:0] t0;
      logic [63:0] t1;
      case ($urandom_range(0, 9))
         0: begin
            t0 = {$urandom, $urandom};
            t1 = {$urandom, $urandom};
         end
         1: begin
            t0 = tnow;
            t1 = tnow - 64'($urandom_range(1, 1000));
         end
         2: begin
            t0 = 64'($urandom_range(0, 3));
            t1 = {1'b1, 63'({$urandom, $urandom})};
         end
         default: begin
            t0 = tnow + 64'($urandom_range(0, 1000));
            t1 = t0 + 64'($urandom_range(0, 5000));
         end
      endcase
      return make_sample(5'($urandom), t0, t1);
   endfunction

   // Count only items that can change state: ticks while disabled are skipped.
   task automatic offer(req_item_type it);
      pending_items.push_back(it);
      if (it.operation == OP_SAMPLE || cfg_enable)
         counted_items++;
   endtask

   // Well-formed window: an opening tick, then advancing ticks with samples between.
   task automatic queue_window_run(int ticks);
      logic [31:0] stage;
      logic [31:0] frame;
      logic [7:0]  cad;
      logic [7:0]  demo;
      logic        rep;
      logic [63:0] tnow;
      int          n;
      stage = $urandom;
      cad   = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
      demo  = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
      rep   = 1'($urandom);
      case ($urandom_range(0, 5))
         0:       frame = $urandom;
         1:       frame = 32'hFFFF_FFFF - $urandom_range(0, 8);
         default: frame = $urandom_range(1, 5000);
      endcase
      tnow = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom);
      offer(make_tick(stage, frame, cad, rep, demo, tnow));
      for (int i = 0; i < ticks; i++) begin
         n = $urandom_range(0, 3);
         repeat (n) offer(random_sample(tnow));
         frame++;
         tnow += 64'($urandom_range(1, 20000));
         // Let the tick clock step back now and then.
         if ($urandom_range(0, 19) == 0)
            tnow -= 64'($urandom_range(0, 100000));
         offer(make_tick(stage, frame, cad, rep, demo, tnow));
      end
   endtask

   // Windows that reach targets of up to 8 frames, with broken ticks and stray samples.
   task automatic queue_random_mix(int count);
      int goal;
      int ticks;
      goal = counted_items + count;
      while (counted_items < goal) begin
         ticks = (cfg_frames != 0 && cfg_frames <= 8) ? int'(cfg_frames) :
                 $urandom_range(1, 4);
         case ($urandom_range(0, 9))
            0: offer(make_tick($urandom, $urandom, 8'($urandom), 1'($urandom),
                               8'($urandom), {$urandom, $urandom}));
            1: offer(make_tick($urandom, '0, 8'($urandom), 1'($urandom),
                               8'($urandom), {$urandom, $urandom}));
            2: offer(random_sample({$urandom, $urandom}));
            default: queue_window_run(ticks);
         endcase
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_ENABLE)
         cfg_enable = data[0];
      else
         cfg_frames = data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Hold new stimulus until every queued item is taken and every report is back.
   task automatic wait_for_idle(int settle);
      do @(negedge clock);
      while (pending_items.size() != 0 || req_bus.valid || due_reports.size() != 0);
      repeat (settle) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Driver: advance to the next pending item once the current one is taken.
   // ---------------------------------------------------------------------------
   req_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_item = pending_items.pop_front();
            req_bus.operation    <= next_item.operation;
            req_bus.phase_id     <= next_item.phase_id;
            req_bus.start_time   <= next_item.start_time;
            req_bus.end_time     <= next_item.end_time;
            req_bus.stage_number <= next_item.stage_number;
            req_bus.stage_frame  <= next_item.stage_frame;
            req_bus.cadence      <= next_item.cadence;
            req_bus.replay_flag  <= next_item.replay_flag;
            req_bus.demo_mode    <= next_item.demo_mode;
            req_bus.valid        <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: random idling, plus a long hold-off whenever a new token shows up.
   int stall_left = 0;
   int stall_seen = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
         stall_seen    <= 0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (stall_seen != stall_token) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= STALL_CYCLES;
         stall_seen    <= stall_token;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: check reports against the oldest expectation, feed the predictor,
   // and watch for a hang.
   // ---------------------------------------------------------------------------
   task automatic check_field(string name, logic [4:0] phase, logic [63:0] want,
                              logic [63:0] got);
      if (got !== want) begin
         $display("%0t: phase %0d %s expected %0h actual %0h", $time, phase, name,
                  want, got);
         mismatches++;
      end
   endtask

   int quiet_cycles = 0;

   always @(posedge clock) begin : monitor
      phase_report_type got;
      phase_report_type want;
      req_item_type     seen;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.phase_index = rsp_bus.phase_index;
            got.total_time  = rsp_bus.total_time;
            got.max_time    = rsp_bus.max_time;
            got.call_count  = rsp_bus.call_count;
            got.draw_count  = rsp_bus.draw_count;
            got.wall_time   = rsp_bus.wall_time;
            got.first_frame = rsp_bus.first_frame;
            got.final_frame = rsp_bus.final_frame;
            got.regressions = rsp_bus.regressions;
            got.last        = rsp_bus.last;
            if (due_reports.size() == 0) begin
               $display("%0t: unexpected report expected none actual phase %0d",
                        $time, got.phase_index);
               mismatches++;
            end else begin
               want = due_reports.pop_front();
               check_field("phase_index", want.phase_index, 64'(want.phase_index),
                           64'(got.phase_index));
               check_field("total_time", want.phase_index, want.total_time,
                           got.total_time);
               check_field("max_time", want.phase_index, want.max_time, got.max_time);
               check_field("call_count", want.phase_index, 64'(want.call_count),
                           64'(got.call_count));
               check_field("draw_count", want.phase_index, 64'(want.draw_count),
                           64'(got.draw_count));
               check_field("wall_time", want.phase_index, want.wall_time, got.wall_time);
               check_field("first_frame", want.phase_index, 64'(want.first_frame),
                           64'(got.first_frame));
               check_field("final_frame", want.phase_index, 64'(want.final_frame),
                           64'(got.final_frame));
               check_field("regressions", want.phase_index, 64'(want.regressions),
                           64'(got.regressions));
               check_field("last", want.phase_index, 64'(want.last), 64'(got.last));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.operation    = req_bus.operation;
            seen.phase_id     = req_bus.phase_id;
            seen.start_time   = req_bus.start_time;
            seen.end_time     = req_bus.end_time;
            seen.stage_number = req_bus.stage_number;
            seen.stage_frame  = req_bus.stage_frame;
            seen.cadence      = req_bus.cadence;
            seen.replay_flag  = req_bus.replay_flag;
            seen.demo_mode    = req_bus.demo_mode;
            update_phase_stats(seen);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus: directed corners first, then random phases under several settings.
   // ---------------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Block still disabled: the tick does nothing and the closed window drops the sample.
      offer(make_tick(32'd1, 32'd5, 8'd0, 1'b0, 8'd0, 64'd100));
      offer(make_sample(5'd0, 64'd0, 64'd10));
      wait_for_idle(8);

      write_csr(CSR_ENABLE, 16'd1);
      write_csr(CSR_WINDOW_FRAMES, 16'd2);

      // Open a window, saturate phase 0, record a zero and a backwards sample.
      offer(make_tick(32'd5, 32'd10, 8'd0, 1'b0, 8'd0, 64'd1000));
      offer(make_sample(5'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF));
      offer(make_sample(5'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF));
      offer(make_sample(5'd31, 64'd5, 64'd5));
      offer(make_sample(5'd3, 64'd100, 64'd50));
      offer(make_sample(5'd7, 64'd10, 64'd30));
      offer(make_tick(32'd5, 32'd11, 8'd0, 1'b0, 8'd0, 64'd1500));
      // Reach the target with a tick time behind the window start: wall time zero.
      offer(make_tick(32'd5, 32'd12, 8'd0, 1'b0, 8'd0, 64'd500));
      // Restart on a stalled frame, a new stage, then each changed mode.
      offer(make_tick(32'd5, 32'd12, 8'd0, 1'b0, 8'd0, 64'd600));
      offer(make_tick(32'd6, 32'd13, 8'd0, 1'b0, 8'd0, 64'd700));
      offer(make_tick(32'd6, 32'd14, 8'd255, 1'b0, 8'd0, 64'd800));
      offer(make_tick(32'd6, 32'd15, 8'd255, 1'b1, 8'd0, 64'd900));
      offer(make_tick(32'd6, 32'd16, 8'd255, 1'b1, 8'd255, 64'd950));
      // Frame zero closes the window; a sample after it is dropped.
      offer(make_tick(32'd6, 32'd0, 8'd255, 1'b1, 8'd255, 64'd960));
      offer(make_sample(5'd1, 64'd0, 64'd40));
      // Overshoot the target, then a frame whose target overflows keeps it closed.
      offer(make_tick(32'h8000_0000, 32'd20, 8'd0, 1'b0, 8'd0, 64'd0));
      offer(make_tick(32'h8000_0000, 32'd25, 8'd0, 1'b0, 8'd0, 64'd10));
      offer(make_tick(32'h8000_0000, 32'hFFFF_FFFF, 8'd0, 1'b0, 8'd0, 64'd20));
      // Full-range wall time on the emitting tick.
      offer(make_tick(32'h7FFF_FFFF, 32'd100, 8'd0, 1'b0, 8'd0, 64'd0));
      offer(make_sample(5'd31, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF));
      offer(make_tick(32'h7FFF_FFFF, 32'd101, 8'd0, 1'b0, 8'd0, 64'd5));
      offer(make_tick(32'h7FFF_FFFF, 32'd102, 8'd0, 1'b0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF));
      wait_for_idle(8);

      write_csr(CSR_WINDOW_FRAMES, 16'($urandom_range(1, 6)));
      queue_random_mix(90);
      wait_for_idle(8);

      // Zero-length windows: every advancing tick restarts.
      write_csr(CSR_WINDOW_FRAMES, 16'd0);
      queue_random_mix(30);
      wait_for_idle(8);

      // Longest windows: the target is never reached here.
      write_csr(CSR_WINDOW_FRAMES, 16'hFFFF);
      queue_random_mix(20);
      wait_for_idle(8);

      // Back-pressure: hold the receiver off while each advancing tick emits a full window.
      write_csr(CSR_WINDOW_FRAMES, 16'd1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_token++;
      queue_window_run(12);
      wait_for_idle(8);
      send_idle_pct = 20;
      recv_idle_pct = 20;

      // Disabled: ticks drop, samples still land in an open window.
      write_csr(CSR_ENABLE, 16'd0);
      queue_random_mix(20);
      wait_for_idle(8);

      write_csr(CSR_ENABLE, 16'd1);
      write_csr(CSR_WINDOW_FRAMES, 16'($urandom_range(2, 5)));
      queue_random_mix((counted_items < ITEM_GOAL) ? ITEM_GOAL - counted_items : 20);
      wait_for_idle(40);

      if (mismatches == 0 && due_reports.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### sim.f
hdl/wpts_pkg.sv
hdl/wpts_req_if.sv
hdl/wpts_rsp_if.sv
hdl/wpts_cell.sv
hdl/windowed_phase_timing_stats.sv
tb/windowed_phase_timing_stats_tb.sv
